// ===== hw/rtl/sstf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the SSTF seek total scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

	// Result field widths
	localparam int MOVE_W  = 22;
	localparam int COUNT_W = 7;

	// Saturation limits of the result fields
	localparam logic [MOVE_W-1:0]  MOVE_MAX  = 22'h3FFFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7F;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sstf_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_req_if
// Request channel: one disk track request per item.
// ----------------------------------------------------------------------------
interface sstf_req_if #(
	parameter int TRACK_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [TRACK_BITS-1:0] track;
	logic [TRACK_BITS-1:0] head_start;
	logic                  first;
	logic                  last;

	modport source (output valid, track, head_start, first, last, input ready);
	modport sink   (input valid, track, head_start, first, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sstf_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_res_if
// Result channel: total head movement, served count and overflow flag.
// ----------------------------------------------------------------------------
interface sstf_res_if;
	logic                         valid;
	logic                         ready;
	logic [sstf_pkg::MOVE_W-1:0]  total_movement;
	logic [sstf_pkg::COUNT_W-1:0] served_count;
	logic                         overflow;

	modport source (output valid, total_movement, served_count, overflow, input ready);
	modport sink   (input valid, total_movement, served_count, overflow, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sstf_req_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_req_mem
// Request store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sstf_req_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sstf_nearest.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_nearest
// Shared distance/compare unit: takes one candidate per cycle and keeps the
// nearest one to the head. Strict compare keeps the earliest on a tie.
// ----------------------------------------------------------------------------
module sstf_nearest #(
	parameter int TRACK_BITS = 16,
	parameter int IDX_W      = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  clr,
	input  wire logic                  cand_valid,
	input  wire logic [TRACK_BITS-1:0] cand_track,
	input  wire logic [IDX_W-1:0]      cand_idx,
	input  wire logic [TRACK_BITS-1:0] head,
	output logic      [TRACK_BITS-1:0] best_dist,
	output logic      [TRACK_BITS-1:0] best_track,
	output logic      [IDX_W-1:0]      best_idx
);

	logic                  found_q;
	logic [TRACK_BITS-1:0] gap;
	logic                  take;

	// Absolute distance and compare against the best so far
	always_comb begin
		gap  = (cand_track >= head) ? (cand_track - head) : (head - cand_track);
		take = cand_valid && (!found_q || (gap < best_dist));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Best candidate payload
	always_ff @(posedge clk) begin
		if (!clr && take) begin
			best_dist  <= gap;
			best_track <= cand_track;
			best_idx   <= cand_idx;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sstf_seek_total_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_seek_total_core
// Shortest-seek-time-first scheduler that reports total head movement.
// ----------------------------------------------------------------------------
// Requests are collected one item per cycle into a store of MAX_REQUESTS
// entries; the item with first set also loads the head position, and extras
// past capacity are dropped and flagged. After the item with last set the
// block serves the set: each of the n service steps scans all n stored
// entries through one distance/compare unit (the SCAN state), drains the
// store read pipeline (DRAIN) and moves the head (COMMIT); the result is
// posted from FINISH after the last step. Input is not ready while serving.
// The result sits in an output register, so the next set may be collected
// while it waits to be taken.
// ----------------------------------------------------------------------------
module sstf_seek_total_core #(
	parameter int MAX_REQUESTS = 64,
	parameter int TRACK_BITS   = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sstf_req_if.sink    req,
	sstf_res_if.source  res
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int SUM_W = (TRACK_BITS + 1 > sstf_pkg::MOVE_W + 1) ?
		(TRACK_BITS + 1) : (sstf_pkg::MOVE_W + 1);

	sstf_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]            cnt_q;
	logic [TRACK_BITS-1:0]       head_q;
	logic [sstf_pkg::MOVE_W-1:0] sum_q;
	logic                        drop_q;
	logic [MAX_REQUESTS-1:0]     mask_q;
	logic [IDX_W-1:0]            rd_idx_q;
	logic [IDX_W-1:0]            step_q;

	logic                        valid_s1;
	logic                        served_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [TRACK_BITS-1:0]       rdata_s1;

	logic                         res_valid_q;
	logic [sstf_pkg::MOVE_W-1:0]  res_total_q;
	logic [sstf_pkg::COUNT_W-1:0] res_count_q;
	logic                         res_over_q;

	logic [TRACK_BITS-1:0] best_dist;
	logic [TRACK_BITS-1:0] best_track;
	logic [IDX_W-1:0]      best_idx;

	logic                  in_ready;
	logic                  mem_re;
	logic                  near_clr;
	logic                  accept;
	logic                  res_free;
	logic [CNT_W-1:0]      cnt_eff;
	logic                  full_eff;
	logic [IDX_W-1:0]      last_idx;
	logic [SUM_W-1:0]      sum_add;
	logic [sstf_pkg::MOVE_W-1:0] sum_next;
	logic [31:0]           cnt_ext;

	// Handshake and derived values
	always_comb begin
		accept   = req.valid && in_ready;
		res_free = !res_valid_q || res.ready;
		cnt_eff  = req.first ? '0 : cnt_q;
		full_eff = (cnt_eff == CNT_W'(MAX_REQUESTS));
		last_idx = IDX_W'(cnt_q - CNT_W'(1));
		sum_add  = SUM_W'(sum_q) + SUM_W'(best_dist);
		sum_next = (sum_add > SUM_W'(sstf_pkg::MOVE_MAX)) ? sstf_pkg::MOVE_MAX :
			sum_add[sstf_pkg::MOVE_W-1:0];
		cnt_ext  = 32'(cnt_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sstf_pkg::ST_COLLECT: begin
				if (accept && req.last) begin
					state_d = sstf_pkg::ST_SCAN;
				end
			end
			sstf_pkg::ST_SCAN: begin
				if (rd_idx_q == last_idx) begin
					state_d = sstf_pkg::ST_DRAIN;
				end
			end
			sstf_pkg::ST_DRAIN: begin
				state_d = sstf_pkg::ST_COMMIT;
			end
			sstf_pkg::ST_COMMIT: begin
				state_d = (step_q == last_idx) ? sstf_pkg::ST_FINISH : sstf_pkg::ST_SCAN;
			end
			sstf_pkg::ST_FINISH: begin
				if (res_free) begin
					state_d = sstf_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_d = sstf_pkg::ST_COLLECT;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		near_clr = 1'b1;
		case (state_q)
			sstf_pkg::ST_COLLECT: begin
				in_ready = 1'b1;
			end
			sstf_pkg::ST_SCAN: begin
				mem_re   = 1'b1;
				near_clr = 1'b0;
			end
			sstf_pkg::ST_DRAIN: begin
				near_clr = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sstf_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Set state: count, head, movement sum, drop flag, served marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			head_q   <= '0;
			sum_q    <= '0;
			drop_q   <= 1'b0;
			mask_q   <= '0;
			rd_idx_q <= '0;
			step_q   <= '0;
		end else begin
			case (state_q)
				sstf_pkg::ST_COLLECT: begin
					if (accept) begin
						if (req.first) begin
							head_q <= req.head_start;
						end
						if (full_eff) begin
							cnt_q  <= cnt_eff;
							drop_q <= 1'b1;
						end else begin
							cnt_q  <= cnt_eff + CNT_W'(1);
							drop_q <= req.first ? 1'b0 : drop_q;
						end
					end
				end
				sstf_pkg::ST_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				sstf_pkg::ST_COMMIT: begin
					sum_q            <= sum_next;
					head_q           <= best_track;
					mask_q[best_idx] <= 1'b1;
					step_q           <= step_q + IDX_W'(1);
					rd_idx_q         <= '0;
				end
				sstf_pkg::ST_FINISH: begin
					if (res_free) begin
						cnt_q  <= '0;
						sum_q  <= '0;
						drop_q <= 1'b0;
						mask_q <= '0;
						step_q <= '0;
					end
				end
				default: begin
					rd_idx_q <= rd_idx_q;
				end
			endcase
		end
	end

	// Read pipeline stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == sstf_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= rd_idx_q;
		served_s1 <= mask_q[rd_idx_q];
	end

	// Request store
	sstf_req_mem #(
		.DEPTH (MAX_REQUESTS),
		.WIDTH (TRACK_BITS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (accept && !full_eff),
		.waddr (cnt_eff[IDX_W-1:0]),
		.wdata (req.track),
		.re    (mem_re),
		.raddr (rd_idx_q),
		.rdata (rdata_s1)
	);

	// Shared nearest-request unit
	sstf_nearest #(
		.TRACK_BITS (TRACK_BITS),
		.IDX_W      (IDX_W)
	) u_near (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (near_clr),
		.cand_valid (valid_s1 && !served_s1),
		.cand_track (rdata_s1),
		.cand_idx   (idx_s1),
		.head       (head_q),
		.best_dist  (best_dist),
		.best_track (best_track),
		.best_idx   (best_idx)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == sstf_pkg::ST_FINISH && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sstf_pkg::ST_FINISH && res_free) begin
			res_total_q <= sum_q;
			res_count_q <= (cnt_ext > 32'(sstf_pkg::COUNT_MAX)) ? sstf_pkg::COUNT_MAX :
				cnt_ext[sstf_pkg::COUNT_W-1:0];
			res_over_q  <= drop_q;
		end
	end

	assign req.ready          = in_ready;
	assign res.valid          = res_valid_q;
	assign res.total_movement = res_total_q;
	assign res.served_count   = res_count_q;
	assign res.overflow       = res_over_q;

endmodule
`default_nettype wire
